@@ rtl/assert_macros.svh @@
// Assertion macros shared by the RTL.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH
// Property checked on every clock edge outside reset.
`define ASSERT_CLK(lbl, clk, rst_n, prop) \
	lbl: assert property (@(posedge clk) disable iff (!rst_n) prop) else $error("assertion failed");
// Condition that must never be true on a clock edge outside reset.
`define ASSERT_NEVER(lbl, clk, rst_n, expr) \
	lbl: assert property (@(posedge clk) disable iff (!rst_n) !(expr)) else $error("forbidden condition");
`endif

@@ rtl/sdspi_pkg.sv @@
// Package: types, codes and CRC7 helper for the SD SPI transfer engine.
`timescale 1ns / 1ps
package sdspi_pkg;
	localparam int BLOCK_BYTES_DEF = 512;

	localparam logic [2:0] REQ_CMD   = 3'd0;
	localparam logic [2:0] REQ_READ  = 3'd1;
	localparam logic [2:0] REQ_WRITE = 3'd2;
	localparam logic [2:0] REQ_CARD  = 3'd3;
	localparam logic [2:0] REQ_WBYTE = 3'd4;

	localparam logic [2:0] ST_OK      = 3'd0;
	localparam logic [2:0] ST_REFUSED = 3'd1;
	localparam logic [2:0] ST_TOKEN   = 3'd2;
	localparam logic [2:0] ST_WREJ    = 3'd3;
	localparam logic [2:0] ST_BUSY    = 3'd4;

	localparam logic [1:0] CFG_RETRY = 2'd0;
	localparam logic [1:0] CFG_RESP  = 2'd1;
	localparam logic [1:0] CFG_TOKEN = 2'd2;
	localparam logic [1:0] CFG_BUSY  = 2'd3;

	localparam logic [4:0] PH_IDLE = 5'd0, PH_FRAME = 5'd1, PH_R1 = 5'd2,
		PH_CMD_DESEL = 5'd3, PH_TOKEN = 5'd4, PH_RDATA = 5'd5, PH_RCRC = 5'd6,
		PH_WTOKEN = 5'd7, PH_WNEED = 5'd8, PH_WDATA = 5'd9, PH_WCRC = 5'd10,
		PH_WSTAT = 5'd11, PH_WREJ = 5'd12, PH_BUSY = 5'd13, PH_END = 5'd14;

	typedef struct packed {
		logic [2:0]  req_type;
		logic [5:0]  cmd_index;
		logic [31:0] cmd_argument;
		logic        deselect_after;
		logic [22:0] start_sector;
		logic [7:0]  block_count;
		logic [7:0]  card_byte;
		logic [7:0]  write_byte;
	} req_t;

	typedef struct packed {
		logic [7:0] mosi_byte;
		logic       mosi_valid;
		logic       card_selected;
		logic [7:0] read_byte;
		logic       read_valid;
		logic       need_write_byte;
		logic       done_res;
		logic [2:0] status;
		logic [7:0] r1_response;
	} rsp_t;

	// Configuration limits, zero already mapped to one.
	typedef struct packed {
		logic [3:0]  retry_limit;
		logic [15:0] resp_limit;
		logic [15:0] token_limit;
		logic [15:0] busy_limit;
	} limits_t;

	// CRC7 (poly 0x09) over one byte, MSB first.
	function automatic logic [6:0] crc7_byte(input logic [6:0] crc, input logic [7:0] data);
		logic [6:0] c;
		logic       fb;
		c = crc;
		for (int i = 7; i >= 0; i--) begin
			fb = c[6] ^ data[i];
			c = {c[5:0], 1'b0};
			if (fb) c = c ^ 7'h09;
		end
		return c;
	endfunction
endpackage

@@ rtl/sdspi_cfg.sv @@
// Configuration register file with zero-as-one limit mapping.
`timescale 1ns / 1ps
module sdspi_cfg (
	input  logic                  clk,
	input  logic                  arst_n,
	input  logic                  cfg_valid,
	output logic                  cfg_ready,
	input  logic [1:0]            cfg_index,
	input  logic [15:0]           cfg_data,
	output sdspi_pkg::limits_t    limits
);
	logic [3:0]  retry_q;
	logic [15:0] resp_q, token_q, busy_q;

	assign cfg_ready = 1'b1;

	// Register writes
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			retry_q <= 4'd3;
			resp_q  <= 16'h1000;
			token_q <= 16'h0FFF;
			busy_q  <= 16'hFFFF;
		end else if (cfg_valid) begin
			unique case (cfg_index)
				sdspi_pkg::CFG_RETRY: retry_q <= cfg_data[3:0];
				sdspi_pkg::CFG_RESP:  resp_q  <= cfg_data;
				sdspi_pkg::CFG_TOKEN: token_q <= cfg_data;
				sdspi_pkg::CFG_BUSY:  busy_q  <= cfg_data;
				default: ;
			endcase
		end
	end

	assign limits.retry_limit = (retry_q == 4'd0) ? 4'd1 : retry_q;
	assign limits.resp_limit  = (resp_q == 16'd0) ? 16'd1 : resp_q;
	assign limits.token_limit = (token_q == 16'd0) ? 16'd1 : token_q;
	assign limits.busy_limit  = (busy_q == 16'd0) ? 16'd1 : busy_q;
endmodule

@@ rtl/sd_spi_block_transfer_engine_unit.sv @@
// Top level: SD card SPI mode byte-exchange engine.
//  channel | direction | handshake          | payload
//  in      | input     | in_valid/in_stall  | in_data (req_t)
//  out     | output    | out_valid/out_stall| out_data (rsp_t)
//  cfg     | input     | cfg_valid/cfg_ready| cfg_index, cfg_data
// One item per cycle when not stalled: a transfer is registered at the input;
// phase logic runs next cycle and the result lands in the output register.
// in_stall rises only when both the input and output registers are full and
// the output is stalled. Reset clears all control state; last R1 reads 0xFF.
`timescale 1ns / 1ps
`include "assert_macros.svh"
module sd_spi_block_transfer_engine_unit #(
	parameter int BLOCK_BYTES = sdspi_pkg::BLOCK_BYTES_DEF
) (
	input  logic              clk,
	input  logic              arst_n,
	input  logic              in_valid,
	output logic              in_stall,
	input  sdspi_pkg::req_t   in_data,
	output logic              out_valid,
	input  logic              out_stall,
	output sdspi_pkg::rsp_t   out_data,
	input  logic              cfg_valid,
	output logic              cfg_ready,
	input  logic [1:0]        cfg_index,
	input  logic [15:0]       cfg_data
);
	localparam int BCW = $clog2(BLOCK_BYTES + 1);

	sdspi_pkg::limits_t lim;
	sdspi_pkg::req_t    req_s1;
	logic               vld_s1;
	logic               adv;

	sdspi_cfg u_cfg (
		.clk(clk), .arst_n(arst_n), .cfg_valid(cfg_valid), .cfg_ready(cfg_ready),
		.cfg_index(cfg_index), .cfg_data(cfg_data), .limits(lim)
	);

	// Stage 1 advances when the output register can take a result.
	assign adv      = !out_valid || !out_stall;
	assign in_stall = vld_s1 && !adv;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) vld_s1 <= 1'b0;
		else if (!in_stall) vld_s1 <= in_valid;
	end
	always_ff @(posedge clk) begin
		if (in_valid && !in_stall) req_s1 <= in_data;
	end

	// Engine state
	logic [4:0]  phase_q, phase_d;
	logic [47:0] frame_q, frame_d;
	logic [BCW-1:0] bc_q, bc_d;
	logic [15:0] wc_q, wc_d;
	logic [3:0]  retry_q, retry_d;
	logic [22:0] sect_q, sect_d;
	logic [7:0]  left_q, left_d;
	logic [1:0]  kind_q, kind_d;
	logic        rel_q, rel_d;
	logic [7:0]  r1_q, r1_d;
	logic        cs_q, cs_d;
	logic [2:0]  jst_q, jst_d;

	logic        emit;
	logic [7:0]  mosi, rdb;
	logic        mv, rv, need, done;
	logic [2:0]  st;
	logic [7:0]  c;
	logic [2:0]  rq;

	// Builds a command frame: command byte, argument, CRC7 and end bit.
	function automatic logic [47:0] mk_frame(input logic [5:0] idx, input logic [31:0] arg);
		logic [7:0] first;
		logic [6:0] crc;
		first = {2'b01, idx};
		crc = sdspi_pkg::crc7_byte(7'd0, first);
		crc = sdspi_pkg::crc7_byte(crc, arg[31:24]);
		crc = sdspi_pkg::crc7_byte(crc, arg[23:16]);
		crc = sdspi_pkg::crc7_byte(crc, arg[15:8]);
		crc = sdspi_pkg::crc7_byte(crc, arg[7:0]);
		return {first, arg, crc, 1'b1};
	endfunction

	// Next state and result
	always_comb begin
		logic        sframe;
		logic [5:0]  fidx;
		logic [31:0] farg;
		logic        ssect;
		phase_d = phase_q; frame_d = frame_q; bc_d = bc_q; wc_d = wc_q;
		retry_d = retry_q; sect_d = sect_q; left_d = left_q; kind_d = kind_q;
		rel_d = rel_q; r1_d = r1_q; cs_d = cs_q; jst_d = jst_q;
		emit = 1'b0; mosi = 8'h00; mv = 1'b0; rdb = 8'h00; rv = 1'b0;
		need = 1'b0; done = 1'b0; st = sdspi_pkg::ST_OK;
		sframe = 1'b0; fidx = 6'd0; farg = 32'd0; ssect = 1'b0;
		c = req_s1.card_byte; rq = req_s1.req_type;
		if (vld_s1) begin
			if (phase_q == sdspi_pkg::PH_IDLE) begin
				if (rq == sdspi_pkg::REQ_CMD || rq == sdspi_pkg::REQ_READ ||
					rq == sdspi_pkg::REQ_WRITE) begin
					emit = 1'b1; kind_d = rq[1:0]; retry_d = 4'd0; jst_d = sdspi_pkg::ST_OK;
					if (rq == sdspi_pkg::REQ_CMD) begin
						rel_d = req_s1.deselect_after;
						sframe = 1'b1; fidx = req_s1.cmd_index; farg = req_s1.cmd_argument;
					end else begin
						rel_d = 1'b0; sect_d = req_s1.start_sector;
						left_d = req_s1.block_count; ssect = 1'b1;
					end
				end
			end else if (phase_q == sdspi_pkg::PH_WNEED) begin
				if (rq == sdspi_pkg::REQ_WBYTE) begin
					emit = 1'b1; phase_d = sdspi_pkg::PH_WDATA; mv = 1'b1;
					mosi = req_s1.write_byte;
				end
			end else if (rq == sdspi_pkg::REQ_CARD) begin
				emit = 1'b1;
				unique case (phase_q)
					sdspi_pkg::PH_FRAME: begin
						bc_d = bc_q + 1'b1; mv = 1'b1;
						if (bc_d < BCW'(6)) begin
							unique case (bc_d[2:0])
								3'd1: mosi = frame_q[39:32];
								3'd2: mosi = frame_q[31:24];
								3'd3: mosi = frame_q[23:16];
								3'd4: mosi = frame_q[15:8];
								default: mosi = frame_q[7:0];
							endcase
						end else begin
							wc_d = 16'd1; phase_d = sdspi_pkg::PH_R1; mosi = 8'hFF;
						end
					end
					sdspi_pkg::PH_R1: begin
						if (c[7] && wc_q < lim.resp_limit) begin
							wc_d = wc_q + 16'd1; mv = 1'b1; mosi = 8'hFF;
						end else begin
							r1_d = c;
							if (kind_q == 2'd0) begin
								if (rel_q) begin
									if (c[3]) retry_d = retry_q + 4'd1;
									cs_d = 1'b0; phase_d = sdspi_pkg::PH_CMD_DESEL;
									mv = 1'b1; mosi = 8'hFF;
								end else begin
									phase_d = sdspi_pkg::PH_IDLE; done = 1'b1;
								end
							end else if (c != 8'd0) begin
								cs_d = 1'b0; phase_d = sdspi_pkg::PH_IDLE; done = 1'b1;
								st = sdspi_pkg::ST_REFUSED;
							end else if (kind_q == 2'd1) begin
								wc_d = 16'd1; phase_d = sdspi_pkg::PH_TOKEN;
								mv = 1'b1; mosi = 8'hFF;
							end else begin
								phase_d = sdspi_pkg::PH_WTOKEN; mv = 1'b1; mosi = 8'hFE;
							end
						end
					end
					sdspi_pkg::PH_CMD_DESEL: begin
						if (r1_q[3] && retry_q < lim.retry_limit) begin
							sframe = 1'b1; fidx = frame_q[45:40]; farg = frame_q[39:8];
						end else begin
							phase_d = sdspi_pkg::PH_IDLE; done = 1'b1;
						end
					end
					sdspi_pkg::PH_TOKEN: begin
						if (c == 8'hFE) begin
							bc_d = '0; phase_d = sdspi_pkg::PH_RDATA; mv = 1'b1; mosi = 8'hFF;
						end else if (wc_q < lim.token_limit) begin
							wc_d = wc_q + 16'd1; mv = 1'b1; mosi = 8'hFF;
						end else begin
							cs_d = 1'b0; phase_d = sdspi_pkg::PH_IDLE; done = 1'b1;
							st = sdspi_pkg::ST_TOKEN;
						end
					end
					sdspi_pkg::PH_RDATA: begin
						bc_d = bc_q + 1'b1;
						if (bc_d >= BCW'(BLOCK_BYTES)) begin
							bc_d = '0; phase_d = sdspi_pkg::PH_RCRC;
						end
						mv = 1'b1; mosi = 8'hFF; rv = 1'b1; rdb = c;
					end
					sdspi_pkg::PH_RCRC: begin
						mv = 1'b1; mosi = 8'hFF;
						if (bc_q == '0) bc_d = BCW'(1);
						else begin
							cs_d = 1'b0; phase_d = sdspi_pkg::PH_END;
						end
					end
					sdspi_pkg::PH_WTOKEN: begin
						bc_d = '0; phase_d = sdspi_pkg::PH_WNEED; need = 1'b1;
					end
					sdspi_pkg::PH_WDATA: begin
						bc_d = bc_q + 1'b1;
						if (bc_d < BCW'(BLOCK_BYTES)) begin
							phase_d = sdspi_pkg::PH_WNEED; need = 1'b1;
						end else begin
							bc_d = '0; phase_d = sdspi_pkg::PH_WCRC; mv = 1'b1; mosi = 8'h00;
						end
					end
					sdspi_pkg::PH_WCRC: begin
						mv = 1'b1;
						if (bc_q == '0) begin
							bc_d = BCW'(1); mosi = 8'h00;
						end else begin
							phase_d = sdspi_pkg::PH_WSTAT; mosi = 8'hFF;
						end
					end
					sdspi_pkg::PH_WSTAT: begin
						mv = 1'b1; mosi = 8'hFF;
						if (c[3:0] == 4'h5) begin
							wc_d = 16'd1; phase_d = sdspi_pkg::PH_BUSY;
						end else begin
							retry_d = retry_q + 4'd1; cs_d = 1'b0;
							phase_d = sdspi_pkg::PH_WREJ;
						end
					end
					sdspi_pkg::PH_WREJ: begin
						if (retry_q < lim.retry_limit) ssect = 1'b1;
						else begin
							jst_d = sdspi_pkg::ST_WREJ; cs_d = 1'b0;
							phase_d = sdspi_pkg::PH_END; mv = 1'b1; mosi = 8'hFF;
						end
					end
					sdspi_pkg::PH_BUSY: begin
						if (c != 8'd0) begin
							cs_d = 1'b0; phase_d = sdspi_pkg::PH_END; mv = 1'b1; mosi = 8'hFF;
						end else if (wc_q < lim.busy_limit) begin
							wc_d = wc_q + 16'd1; mv = 1'b1; mosi = 8'hFF;
						end else begin
							cs_d = 1'b0; phase_d = sdspi_pkg::PH_IDLE; done = 1'b1;
							st = sdspi_pkg::ST_BUSY;
						end
					end
					sdspi_pkg::PH_END: begin
						if (jst_q != sdspi_pkg::ST_OK) begin
							phase_d = sdspi_pkg::PH_IDLE; done = 1'b1; st = jst_q;
						end else begin
							left_d = left_q - 8'd1; sect_d = sect_q + 23'd1;
							retry_d = 4'd0; ssect = 1'b1;
						end
					end
					default: emit = 1'b0;
				endcase
			end
		end
		// Start of a sector: finish on zero count, else frame CMD17/CMD24.
		if (ssect) begin
			if (left_d == 8'd0) begin
				phase_d = sdspi_pkg::PH_IDLE; done = 1'b1; st = sdspi_pkg::ST_OK;
				mv = 1'b0; mosi = 8'h00;
			end else begin
				sframe = 1'b1;
				fidx = (kind_d == 2'd1) ? 6'd17 : 6'd24;
				farg = {sect_d, 9'd0};
			end
		end
		if (sframe) begin
			frame_d = mk_frame(fidx, farg); bc_d = '0; cs_d = 1'b1;
			phase_d = sdspi_pkg::PH_FRAME; mv = 1'b1; mosi = frame_d[47:40];
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			phase_q <= sdspi_pkg::PH_IDLE; frame_q <= '0; bc_q <= '0; wc_q <= '0;
			retry_q <= '0; sect_q <= '0; left_q <= '0; kind_q <= '0; rel_q <= 1'b0;
			r1_q <= 8'hFF; cs_q <= 1'b0; jst_q <= sdspi_pkg::ST_OK;
		end else if (vld_s1 && adv) begin
			phase_q <= phase_d; frame_q <= frame_d; bc_q <= bc_d; wc_q <= wc_d;
			retry_q <= retry_d; sect_q <= sect_d; left_q <= left_d; kind_q <= kind_d;
			rel_q <= rel_d; r1_q <= r1_d; cs_q <= cs_d; jst_q <= jst_d;
		end
	end

	// Output register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) out_valid <= 1'b0;
		else if (adv) out_valid <= vld_s1 && emit;
	end
	always_ff @(posedge clk) begin
		if (adv && vld_s1 && emit) begin
			out_data.mosi_byte       <= mosi;
			out_data.mosi_valid      <= mv;
			out_data.card_selected   <= cs_d;
			out_data.read_byte       <= rdb;
			out_data.read_valid      <= rv;
			out_data.need_write_byte <= need;
			out_data.done_res        <= done;
			out_data.status          <= done ? st : sdspi_pkg::ST_OK;
			out_data.r1_response     <= r1_d;
		end
	end

	`ASSERT_CLK(a_stall_hold, clk, arst_n, in_stall |-> vld_s1 && out_valid)
	`ASSERT_CLK(a_idle_desel, clk, arst_n, (phase_q == sdspi_pkg::PH_END) |-> !cs_q)
	`ASSERT_NEVER(a_mosi_done, clk, arst_n, out_valid && out_data.mosi_valid && out_data.done_res)
	`ASSERT_NEVER(a_mosi_need, clk, arst_n, out_valid && out_data.mosi_valid && out_data.need_write_byte)
endmodule
